[sv/awpr_pkg.sv]
// ----------------------------------------------------------------------------
// awpr_pkg
// Shared types and constants for the audio word pairer and rate meter.
// ----------------------------------------------------------------------------
package awpr_pkg;

  localparam int HALF_W   = 16;
  localparam int CNT_W    = 32;
  localparam int TICK_W   = 24;
  localparam int PROD_W   = CNT_W + 20;   // count times one million
  localparam int DCNT_W   = 5;

  localparam logic [TICK_W-1:0] MAX24            = 24'hFF_FFFF;
  localparam logic [TICK_W-1:0] IDLE_LIMIT_RESET = 24'd200000;
  localparam logic [TICK_W-1:0] WINDOW_RESET     = 24'd500000;
  localparam logic [19:0]       US_PER_SECOND    = 20'd1000000;
  localparam logic [DCNT_W-1:0] DIV_STEPS        = 5'd24;

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_RESTART_EN    = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT    = 2'd2;
  localparam logic [1:0] REG_WINDOW        = 2'd3;

  // word kinds on the input stream
  localparam logic OP_WORD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic load_in;    // latch the accepted input word
    logic load_mul;   // register count delta times one million
    logic div_start;  // launch the rate division
    logic commit;     // update state and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;   // current tick closes a measurement window
    logic div_done;
    logic out_free;   // output register can take a new word
  } ctrl_status_t;

endpackage

[sv/awpr_div.sv]
// ----------------------------------------------------------------------------
// awpr_div
// Restoring divider, one quotient bit per cycle, 24-bit saturating result.
// ----------------------------------------------------------------------------
module awpr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [awpr_pkg::PROD_W-1:0]   dividend,
  input  logic [awpr_pkg::TICK_W-1:0]   divisor,
  output logic                          done,
  output logic [awpr_pkg::TICK_W-1:0]   quotient
);
  import awpr_pkg::*;

  logic                busy;
  logic                sat;
  logic [TICK_W-1:0]   rem;
  logic [TICK_W-1:0]   quo;
  logic [DCNT_W-1:0]   cnt;
  logic [TICK_W:0]     trial;
  logic                ge;
  logic [TICK_W-1:0]   rem_step;
  logic                too_big;

  // quotient overflows 24 bits when the upper part already reaches the divisor
  assign too_big  = dividend[PROD_W-1:TICK_W] >= {{(PROD_W-2*TICK_W){1'b0}}, divisor};
  assign trial    = {rem, quo[TICK_W-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_step = ge ? TICK_W'(trial - {1'b0, divisor}) : trial[TICK_W-1:0];
  assign quotient = sat ? MAX24 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= !too_big;
      done <= too_big;
    end else if (busy && cnt == DCNT_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= too_big;
      rem <= dividend[2*TICK_W-1:TICK_W];
      quo <= dividend[TICK_W-1:0];
      cnt <= DIV_STEPS;
    end else if (busy) begin
      rem <= rem_step;
      quo <= {quo[TICK_W-2:0], ge};
      cnt <= cnt - DCNT_W'(1);
    end
  end

endmodule

[sv/awpr_dp.sv]
// ----------------------------------------------------------------------------
// awpr_dp
// Datapath: config registers, run state, next-state logic, output register.
// ----------------------------------------------------------------------------
module awpr_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [23:0]            cfg_data,
  input  logic [39:0]            s_tdata,
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [127:0]           m_tdata,
  input  awpr_pkg::ctrl_cmd_t    cmd,
  output awpr_pkg::ctrl_status_t status
);
  import awpr_pkg::*;

  // configuration
  logic              source_format;
  logic              restart_en;
  logic [TICK_W-1:0] idle_limit;
  logic [TICK_W-1:0] window_len;

  // run state
  logic              pair_phase;
  logic [HALF_W-1:0] held_half;
  logic [CNT_W-1:0]  delivered_total;
  logic [CNT_W-1:0]  dropped_total;
  logic [CNT_W-1:0]  window_start;
  logic [TICK_W-1:0] window_ticks;
  logic [TICK_W-1:0] idle_ticks;
  logic [TICK_W-1:0] rate_value;

  // latched input word
  logic              op_q;
  logic [CNT_W-1:0]  word_q;
  logic              space_q;

  // division operands
  logic [PROD_W-1:0] prod_q;
  logic [TICK_W-1:0] den_q;
  logic [PROD_W-1:0] mult;
  logic              div_done;
  logic [TICK_W-1:0] div_q;

  logic [HALF_W-1:0] half;
  logic [TICK_W-1:0] idle_inc;
  logic [TICK_W-1:0] win_inc;
  logic              restart_hit;
  logic              win_end;

  // next values
  logic              pair_phase_next;
  logic [HALF_W-1:0] held_half_next;
  logic [CNT_W-1:0]  delivered_next;
  logic [CNT_W-1:0]  dropped_next;
  logic [CNT_W-1:0]  window_start_next;
  logic [TICK_W-1:0] window_ticks_next;
  logic [TICK_W-1:0] idle_ticks_next;
  logic [TICK_W-1:0] rate_next;
  logic              valid_o;
  logic              drop_o;
  logic              upd_o;
  logic              rst_o;
  logic [HALF_W-1:0] left_o;
  logic [HALF_W-1:0] right_o;

  awpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_q),
    .divisor  (den_q),
    .done     (div_done),
    .quotient (div_q)
  );

  assign half        = source_format ? word_q[15:0] : word_q[23:8];
  assign idle_inc    = (idle_ticks == MAX24) ? idle_ticks : idle_ticks + TICK_W'(1);
  assign win_inc     = (window_ticks == MAX24) ? window_ticks : window_ticks + TICK_W'(1);
  assign restart_hit = restart_en && (idle_inc > idle_limit);
  assign win_end     = win_inc >= window_len;
  assign mult        = {20'd0, delivered_total - window_start} * {32'd0, US_PER_SECOND};

  assign status.need_div = (op_q == OP_TICK) && !restart_hit && win_end;
  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid || m_tready;

  always_comb begin
    pair_phase_next   = pair_phase;
    held_half_next    = held_half;
    delivered_next    = delivered_total;
    dropped_next      = dropped_total;
    window_start_next = window_start;
    window_ticks_next = window_ticks;
    idle_ticks_next   = idle_ticks;
    rate_next         = rate_value;
    valid_o           = 1'b0;
    drop_o            = 1'b0;
    upd_o             = 1'b0;
    rst_o             = 1'b0;
    left_o            = '0;
    right_o           = '0;
    if (op_q == OP_WORD) begin
      idle_ticks_next = '0;
      if (!pair_phase) begin
        held_half_next  = half;
        pair_phase_next = 1'b1;
      end else begin
        pair_phase_next = 1'b0;
        if (space_q) begin
          valid_o        = 1'b1;
          left_o         = source_format ? half : held_half;
          right_o        = source_format ? held_half : half;
          delivered_next = delivered_total + CNT_W'(1);
        end else begin
          drop_o       = 1'b1;
          dropped_next = dropped_total + CNT_W'(1);
        end
      end
    end else begin
      idle_ticks_next = idle_inc;
      if (restart_hit) begin
        pair_phase_next   = 1'b0;
        held_half_next    = '0;
        delivered_next    = '0;
        dropped_next      = '0;
        window_start_next = '0;
        window_ticks_next = '0;
        idle_ticks_next   = '0;
        rst_o             = 1'b1;
      end else if (win_end) begin
        rate_next         = div_q;
        window_start_next = delivered_total;
        window_ticks_next = '0;
        upd_o             = 1'b1;
      end else begin
        window_ticks_next = win_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= 1'b0;
      restart_en    <= 1'b1;
      idle_limit    <= IDLE_LIMIT_RESET;
      window_len    <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_FORMAT: source_format <= cfg_data[0];
        REG_RESTART_EN:    restart_en    <= cfg_data[0];
        REG_IDLE_LIMIT:    idle_limit    <= cfg_data;
        REG_WINDOW:        window_len    <= cfg_data;
        default:           source_format <= source_format;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_phase      <= 1'b0;
      held_half       <= '0;
      delivered_total <= '0;
      dropped_total   <= '0;
      window_start    <= '0;
      window_ticks    <= '0;
      idle_ticks      <= '0;
      rate_value      <= '0;
    end else if (cmd.commit) begin
      pair_phase      <= pair_phase_next;
      held_half       <= held_half_next;
      delivered_total <= delivered_next;
      dropped_total   <= dropped_next;
      window_start    <= window_start_next;
      window_ticks    <= window_ticks_next;
      idle_ticks      <= idle_ticks_next;
      rate_value      <= rate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= s_tuser;
      word_q  <= s_tdata[31:0];
      space_q <= s_tdata[32];
    end
    if (cmd.load_mul) begin
      prod_q <= mult;
      den_q  <= win_inc;
    end
    if (cmd.commit) begin
      m_tdata <= {4'd0, rst_o, upd_o, rate_next, delivered_next, dropped_next,
                  drop_o, right_o, left_o, valid_o};
    end
  end

endmodule

[sv/awpr_ctrl.sv]
// ----------------------------------------------------------------------------
// awpr_ctrl
// Controller: sequences accept, optional rate division and commit.
// ----------------------------------------------------------------------------
module awpr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  awpr_pkg::ctrl_status_t status,
  output awpr_pkg::ctrl_cmd_t    cmd
);
  import awpr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load_in   = s_tvalid && (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.need_div) begin
          state_next = ST_MUL;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.load_mul = 1'b1;
        state_next   = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/audio_word_pairer_with_rate_meter.sv]
// ----------------------------------------------------------------------------
// audio_word_pairer_with_rate_meter
// Pairs serial-audio words into stereo samples and meters the sample rate.
// ----------------------------------------------------------------------------
// Each input word is either a captured 32-bit audio word (tuser = 0) or one
// microsecond tick (tuser = 1), and each produces exactly one output word.
// Audio words are paired into a stereo sample: format 0 is left-first and
// takes bits 23:8, format 1 is right-first and takes bits 15:0. A finished
// sample is passed on when ring_has_space is set, else it is dropped and
// counted. Ticks advance an idle timer (auto restart after too much silence
// when enabled) and a measurement window; at window end the rate is
// delivered * 1000000 / window, saturated to 24 bits.
// Steps: an audio word or an ordinary tick is accepted, then committed into
// the output register. A tick that closes a window is accepted, registers
// the count delta times one million, starts the divider, waits through the
// 24 steps of the one-bit-per-cycle rate divider and then commits; when the
// rate saturates the divider finishes at once. The next word is accepted
// while a result still waits in the output register; a commit waits only
// if that register is still full. Configuration writes take effect on the
// next cycle and are to be made while the block is idle.
// ----------------------------------------------------------------------------
module audio_word_pairer_with_rate_meter (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // raw_word[31:0], ring_has_space[32], zero fill
  input  logic         s_tuser,   // operation: 0 audio word, 1 tick
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // sample_valid[0], left_sample[16:1],
                                  // right_sample[32:17], dropped[33],
                                  // drop_count[65:34], delivered_count[97:66],
                                  // rate_estimate[121:98], rate_updated[122],
                                  // restarted[123], zero fill
);
  import awpr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencing: accept, optional multiply/divide, commit
  awpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // state, next-state logic, rate divider and output register
  awpr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio word pairer and sample rate meter.
// ----------------------------------------------------------------------------
// Audio words and microsecond ticks go in on the input stream. A scoreboard
// keeps its own copy of the pairing, counter, idle and window state and
// predicts the one result word that every input word causes. Results are
// checked in order, field by field. Both stream sides idle at random. The
// run walks through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving
  localparam int HOLD_CYCLES    = 500;   // long receiver hold-off
  localparam int TAIL_CYCLES    = 40;    // longer than the slowest word

  // result word layout, lowest bit first from the bottom of the struct
  typedef struct packed {
    logic        restarted;
    logic        rate_updated;
    logic [23:0] rate;
    logic [31:0] delivered;
    logic [31:0] drops;
    logic        dropped;
    logic [15:0] right;
    logic [15:0] left;
    logic        sample_valid;
  } sample_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow state of the pairer/meter plus the queue of result
  // words still owed by the block.
  // --------------------------------------------------------------------------
  class sample_scoreboard;
    // register shadows
    logic        fmt_right_first;
    logic        restart_en;
    logic [23:0] idle_limit;
    logic [23:0] window_len;
    // run state
    logic        second_word;
    logic [15:0] held_half;
    logic [31:0] delivered;
    logic [31:0] drops;
    logic [31:0] window_base;
    logic [23:0] window_ticks;
    logic [23:0] idle_ticks;
    logic [23:0] rate;

    sample_result_t owed_q[$];
    int             errors;

    function new();
      fmt_right_first = 1'b0;
      restart_en      = 1'b1;
      idle_limit      = IDLE_LIMIT_RESET;
      window_len      = WINDOW_RESET;
      clear_run();
      rate   = '0;
      errors = 0;
    endfunction

    function void clear_run();
      second_word  = 1'b0;
      held_half    = '0;
      delivered    = '0;
      drops        = '0;
      window_base  = '0;
      window_ticks = '0;
      idle_ticks   = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_SOURCE_FORMAT: fmt_right_first = val[0];
        REG_RESTART_EN:    restart_en      = val[0];
        REG_IDLE_LIMIT:    idle_limit      = val;
        REG_WINDOW:        window_len      = val;
        default: ;
      endcase
    endfunction

    // predict the result of one accepted input word
    function void note_input(logic op, logic [31:0] word, logic space);
      sample_result_t r;
      logic [15:0]    half;
      logic [63:0]    since;
      logic [63:0]    quot;
      r = '0;
      if (op == OP_WORD) begin
        half = fmt_right_first ? word[15:0] : word[23:8];
        idle_ticks = '0;
        if (!second_word) begin
          // first half is picked now and held for the partner word
          held_half   = half;
          second_word = 1'b1;
        end else begin
          second_word = 1'b0;
          if (space) begin
            r.sample_valid = 1'b1;
            if (fmt_right_first) begin
              r.right = held_half;
              r.left  = half;
            end else begin
              r.left  = held_half;
              r.right = half;
            end
            delivered = delivered + 32'd1;
          end else begin
            r.dropped = 1'b1;
            drops     = drops + 32'd1;
          end
        end
      end else begin
        if (idle_ticks != MAX24) idle_ticks = idle_ticks + 24'd1;
        if (restart_en && idle_ticks > idle_limit) begin
          // rate is kept across a restart, no window check this tick
          clear_run();
          r.restarted = 1'b1;
        end else begin
          if (window_ticks != MAX24) window_ticks = window_ticks + 24'd1;
          if (window_ticks >= window_len) begin
            since = {32'd0, delivered - window_base};
            quot  = since * 64'd1000000 / {40'd0, window_ticks};
            rate  = (quot > {40'd0, MAX24}) ? MAX24 : quot[23:0];
            window_base    = delivered;
            window_ticks   = '0;
            r.rate_updated = 1'b1;
          end
        end
      end
      r.drops     = drops;
      r.delivered = delivered;
      r.rate      = rate;
      owed_q.push_back(r);
    endfunction

    function void log_mismatch(string what, logic [123:0] want, logic [123:0] got);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch%s: expected %h got %h", $realtime, what, want, got);
    endfunction

    function void check_result(logic [127:0] data);
      sample_result_t got;
      sample_result_t want;
      string          bad;
      got = data[123:0];
      if (owed_q.size() == 0) begin
        log_mismatch(" (no word owed)", '0, got);
        return;
      end
      want = owed_q.pop_front();
      bad  = "";
      if (got.sample_valid !== want.sample_valid) bad = {bad, " sample_valid"};
      if (got.left         !== want.left)         bad = {bad, " left_sample"};
      if (got.right        !== want.right)        bad = {bad, " right_sample"};
      if (got.dropped      !== want.dropped)      bad = {bad, " dropped"};
      if (got.drops        !== want.drops)        bad = {bad, " drop_count"};
      if (got.delivered    !== want.delivered)    bad = {bad, " delivered_count"};
      if (got.rate         !== want.rate)         bad = {bad, " rate_estimate"};
      if (got.rate_updated !== want.rate_updated) bad = {bad, " rate_updated"};
      if (got.restarted    !== want.restarted)    bad = {bad, " restarted"};
      if (bad != "") log_mismatch(bad, want, got);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // raw_word[31:0], ring_has_space[32], zero fill
  logic         s_tuser;   // operation
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // sample_valid[0] .. restarted[123], zero fill

  audio_word_pairer_with_rate_meter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_scoreboard sb = new();

  logic calm_send = 1'b0;  // sender offers back to back
  logic calm_recv = 1'b0;  // receiver always ready
  logic hold_req  = 1'b0;  // asks the receiver for one long hold-off
  logic hold_done = 1'b0;  // receiver has served the hold-off
  int   quiet_cycles = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: inputs feed the predictor, results are checked as they leave.
  // Values read right at the clock edge are the ones the DUT saw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_input(s_tuser, s_tdata[31:0], s_tdata[32]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
  end

  // watchdog: trips when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready bursts broken by random stalls, plus one long hold-off
  // on request so the block backs up and drops s_tready.
  // --------------------------------------------------------------------------
  initial begin
    int run_len;
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= 1'b1;
      run_len = calm_recv ? 16 : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      gap = calm_recv ? 0 : pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side tasks, all entered at a rising edge
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [31:0] word, input logic space);
    int gap;
    gap = calm_send ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, space, word};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic random_items(input int n, input int tick_pct, input int space_pct);
    for (int i = 0; i < n; i++)
      send_item(($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WORD, $urandom,
                $urandom_range(0, 99) < space_pct);
  endtask

  // stop sending and wait for every owed result; the extra edge lets the
  // monitor log the last accepted word first
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_config(input logic fmt, input logic en, input logic [23:0] lim,
                              input logic [23:0] win);
    drain_results();
    cfg_write(REG_SOURCE_FORMAT, {23'd0, fmt});
    cfg_write(REG_RESTART_EN, {23'd0, en});
    cfg_write(REG_IDLE_LIMIT, lim);
    cfg_write(REG_WINDOW, win);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic        fmt_sel;
    logic        en_sel;
    logic [23:0] lim_sel;
    logic [23:0] win_sel;
    int          tick_pct;
    int          space_pct;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SOURCE_FORMAT;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tuser   <= OP_WORD;
    s_tdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // -- directed, reset settings: left first, bits 23:8
    send_item(OP_WORD, 32'hFFFF_FFFF, 1'b0);  // first word, space ignored
    send_item(OP_WORD, 32'h0000_0000, 1'b1);  // full-scale left, zero right
    send_item(OP_WORD, 32'h0080_0000, 1'b1);  // most negative half
    send_item(OP_WORD, 32'hFF7F_FFFF, 1'b1);  // most positive half
    send_item(OP_WORD, 32'h1234_5678, 1'b1);
    send_item(OP_WORD, 32'h9ABC_DEF0, 1'b0);  // ring full: sample dropped
    send_item(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_TICK, 32'h0000_0000, 1'b0);

    // -- directed, right first bits 15:0, tiny limit and window
    apply_config(1'b1, 1'b1, 24'd2, 24'd2);
    send_item(OP_WORD, 32'h0000_FFFF, 1'b1);
    send_item(OP_WORD, 32'hFFFF_8000, 1'b1);
    send_item(OP_TICK, 32'h0, 1'b1);          // window closes, rate computed
    send_item(OP_TICK, 32'h0, 1'b1);
    send_item(OP_TICK, 32'h0, 1'b1);          // idle past limit: restart
    send_item(OP_TICK, 32'h0, 1'b1);

    // format flips between the two words of a pair: first half is chosen
    // at its arrival, placement follows the format at the second word
    send_item(OP_WORD, 32'h1234_5678, 1'b1);
    drain_results();
    cfg_write(REG_SOURCE_FORMAT, 24'd0);
    cfg_we <= 1'b0;
    send_item(OP_WORD, 32'hABCD_EF01, 1'b1);
    send_item(OP_WORD, 32'h7FFF_FFFF, 1'b1);
    send_item(OP_WORD, 32'h8000_0000, 1'b0);

    // -- random phases
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin  // largest limit and window: no restart, no window end
          fmt_sel = 1'b0; en_sel = 1'b1; lim_sel = MAX24; win_sel = MAX24;
          tick_pct = 30; space_pct = 80;
        end
        1: begin  // smallest: window ends every tick that does not restart, restart after 2 ticks
          fmt_sel = 1'b1; en_sel = 1'b1; lim_sel = 24'd1; win_sel = 24'd1;
          tick_pct = 25; space_pct = 80;
        end
        2: begin  // restart off, rare ticks: rate can saturate
          fmt_sel = 1'b0; en_sel = 1'b0; lim_sel = 24'd1; win_sel = 24'd1;
          tick_pct = 3; space_pct = 90;
        end
        3: begin
          fmt_sel = 1'b1; en_sel = 1'b0; lim_sel = MAX24;
          win_sel = 24'($urandom_range(1, 60));
          tick_pct = 50; space_pct = 50;
        end
        default: begin
          fmt_sel   = 1'($urandom_range(0, 1));
          en_sel    = 1'($urandom_range(0, 1));
          lim_sel   = 24'($urandom_range(1, 40));
          win_sel   = 24'($urandom_range(1, 80));
          tick_pct  = $urandom_range(10, 60);
          space_pct = $urandom_range(30, 100);
        end
      endcase
      apply_config(fmt_sel, en_sel, lim_sel, win_sel);
      calm_send = (p == 4);
      calm_recv = (p == 4);
      if (p == 5) begin
        // receiver stalls long while we keep offering
        random_items(40, tick_pct, space_pct);
        hold_req = 1'b1;
        random_items(210, tick_pct, space_pct);
      end else if (p == 6) begin
        // sender pauses until the block has nothing left to give
        random_items(100, tick_pct, space_pct);
        drain_results();
        random_items(150, tick_pct, space_pct);
      end else begin
        random_items(250, tick_pct, space_pct);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
